### design/mea_pkg.sv
// mea_pkg: shared types, outcome codes and decode constants for the mips execute alu
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mea_pkg;

   // outcome codes
   localparam logic [2:0] OUT_ALU     = 3'd0;
   localparam logic [2:0] OUT_HILO    = 3'd1;
   localparam logic [2:0] OUT_DIVZERO = 3'd2;
   localparam logic [2:0] OUT_NOWORK  = 3'd3;
   localparam logic [2:0] OUT_UNKNOWN = 3'd4;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // special function codes
   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MTHI  = 6'h11;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MTLO  = 6'h13;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1A;
   localparam logic [5:0] FN_DIVU  = 6'h1B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLT   = 6'h2A;

   // one quotient bit per divider stage
   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } mea_req_type;

   typedef struct packed {
      logic [31:0] alu_value;
      logic [31:0] hi_value;
      logic [31:0] lo_value;
      logic [2:0]  outcome;
   } mea_rsp_type;

   // work carried down the pipeline
   typedef struct packed {
      logic [2:0]  outcome;
      logic        is_div;
      logic        neg_q;
      logic        neg_r;
      logic [31:0] divisor;
      logic [31:0] rem;
      logic [31:0] quo;
      logic [31:0] alu;
      logic [49:0] pp_lo;
      logic [49:0] pp_hi;
   } mea_pipe_type;

endpackage

### design/mips_execute_alu_top.sv
// mips_execute_alu_top: top level, decode stage, divider chain and result register
// depends on mea_pkg, mea_decode and mea_div_stage
`timescale 1ns / 1ps

// MIPS32 integer execute unit. One request is taken every cycle unless a
// result stall holds the pipeline. Each request passes the decode stage,
// 32 divider stages and the result register; every instruction travels
// the full chain so results leave in order. The 32-step restoring divider,
// one quotient bit per stage, sets the depth. The multiply is split into two
// 33x17 partial products in decode and summed at the end. A stall on the
// result side freezes the whole pipeline and is passed back on req_stall.

module mips_execute_alu_top
   import mea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  mea_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output mea_rsp_type rsp_payload
);

   logic         advance;
   logic         stage_valid [DIV_STEPS+1];
   mea_pipe_type stage_pipe  [DIV_STEPS+1];

   logic         rsp_valid_ff;
   mea_rsp_type  rsp_ff, rsp_in;
   mea_pipe_type last;
   logic [65:0]  prod;

   // pipeline moves when the result register is empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   mea_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (req_valid),
      .req_in    (req_payload),
      .valid_out (stage_valid[0]),
      .pipe_out  (stage_pipe[0])
   );

   // divider chain
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      mea_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (stage_valid[i]),
         .pipe_in   (stage_pipe[i]),
         .valid_out (stage_valid[i+1]),
         .pipe_out  (stage_pipe[i+1])
      );
   end

   assign last = stage_pipe[DIV_STEPS];
   assign prod = {{16{last.pp_lo[49]}}, last.pp_lo}
               + {last.pp_hi, 16'h0000};

   // sign fix for divide, product sum, result select
   always_comb begin
      rsp_in = '0;
      rsp_in.outcome = last.outcome;
      case (last.outcome)
         OUT_ALU: rsp_in.alu_value = last.alu;
         OUT_HILO: begin
            if (last.is_div) begin
               rsp_in.lo_value = last.neg_q ? (32'd0 - last.quo) : last.quo;
               rsp_in.hi_value = last.neg_r ? (32'd0 - last.rem) : last.rem;
            end else begin
               rsp_in.hi_value = prod[63:32];
               rsp_in.lo_value = prod[31:0];
            end
         end
         default: rsp_in.outcome = last.outcome;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### design/mea_decode.sv
// mea_decode: first stage, decodes the instruction, runs the alu and forms product halves
// depends on mea_pkg
`timescale 1ns / 1ps

module mea_decode
   import mea_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         valid_in,
   input  mea_req_type  req_in,
   output logic         valid_out,
   output mea_pipe_type pipe_out
);

   logic         valid_ff, valid_in_n;
   mea_pipe_type pipe_ff, pipe_in;

   logic [5:0]  op, fn;
   logic [4:0]  sh;
   logic [31:0] a, b, imz, ims;
   logic        sgn_mul;
   logic [32:0] a33, b33;
   logic signed [49:0] pp_lo_w, pp_hi_w;

   assign op  = req_in.instruction[31:26];
   assign fn  = req_in.instruction[5:0];
   assign sh  = req_in.instruction[10:6];
   assign a   = req_in.operand_a;
   assign b   = req_in.operand_b;
   assign imz = {16'h0000, req_in.instruction[15:0]};
   assign ims = {{16{req_in.instruction[15]}}, req_in.instruction[15:0]};

   // operands extended to 33 bits so the same signed partial-product multipliers serve both forms
   assign sgn_mul = (fn == FN_MULT);
   assign a33 = {sgn_mul & a[31], a};
   assign b33 = {sgn_mul & b[31], b};

   // 33x17 partial products, sign extended to the full 50 bits
   assign pp_lo_w = $signed(a33) * $signed({1'b0, b33[15:0]});
   assign pp_hi_w = $signed(a33) * $signed(b33[32:16]);

   // decode and alu
   always_comb begin
      pipe_in = '0;
      pipe_in.outcome = OUT_UNKNOWN;
      pipe_in.pp_lo = pp_lo_w;
      pipe_in.pp_hi = pp_hi_w;
      if (op == OP_SPECIAL) begin
         case (fn)
            FN_SLL: begin pipe_in.alu = b << sh; pipe_in.outcome = OUT_ALU; end
            FN_SRL: begin pipe_in.alu = b >> sh; pipe_in.outcome = OUT_ALU; end
            FN_SRA: begin
               pipe_in.alu = 32'($signed(b) >>> sh);
               pipe_in.outcome = OUT_ALU;
            end
            FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO: pipe_in.outcome = OUT_NOWORK;
            FN_MULT, FN_MULTU: pipe_in.outcome = OUT_HILO;
            FN_DIV: begin
               if (b == 32'd0) begin
                  pipe_in.outcome = OUT_DIVZERO;
               end else begin
                  pipe_in.outcome = OUT_HILO;
                  pipe_in.is_div  = 1'b1;
                  pipe_in.neg_q   = a[31] ^ b[31];
                  pipe_in.neg_r   = a[31];
                  pipe_in.quo     = a[31] ? (32'd0 - a) : a;
                  pipe_in.divisor = b[31] ? (32'd0 - b) : b;
               end
            end
            FN_DIVU: begin
               if (b == 32'd0) begin
                  pipe_in.outcome = OUT_DIVZERO;
               end else begin
                  pipe_in.outcome = OUT_HILO;
                  pipe_in.is_div  = 1'b1;
                  pipe_in.quo     = a;
                  pipe_in.divisor = b;
               end
            end
            FN_ADD, FN_ADDU: begin pipe_in.alu = a + b; pipe_in.outcome = OUT_ALU; end
            FN_SUB, FN_SUBU: begin pipe_in.alu = a - b; pipe_in.outcome = OUT_ALU; end
            FN_AND: begin pipe_in.alu = a & b; pipe_in.outcome = OUT_ALU; end
            FN_OR:  begin pipe_in.alu = a | b; pipe_in.outcome = OUT_ALU; end
            FN_XOR: begin pipe_in.alu = a ^ b; pipe_in.outcome = OUT_ALU; end
            FN_NOR: begin pipe_in.alu = ~(a | b); pipe_in.outcome = OUT_ALU; end
            FN_SLT: begin
               pipe_in.alu = {31'd0, $signed(a) < $signed(b)};
               pipe_in.outcome = OUT_ALU;
            end
            default: pipe_in.outcome = OUT_UNKNOWN;
         endcase
      end else begin
         case (op)
            OP_ADDI, OP_ADDIU: begin pipe_in.alu = a + ims; pipe_in.outcome = OUT_ALU; end
            OP_SLTI: begin
               pipe_in.alu = {31'd0, $signed(a) < $signed(ims)};
               pipe_in.outcome = OUT_ALU;
            end
            OP_ANDI: begin pipe_in.alu = a & imz; pipe_in.outcome = OUT_ALU; end
            OP_ORI:  begin pipe_in.alu = a | imz; pipe_in.outcome = OUT_ALU; end
            OP_XORI: begin pipe_in.alu = a ^ imz; pipe_in.outcome = OUT_ALU; end
            OP_LUI, OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW:
               pipe_in.outcome = OUT_NOWORK;
            default: pipe_in.outcome = OUT_UNKNOWN;
         endcase
      end
   end

   assign valid_in_n = valid_in;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in_n;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   assign valid_out = valid_ff;
   assign pipe_out  = pipe_ff;

endmodule

### design/mea_div_stage.sv
// mea_div_stage: one restoring division step, one quotient bit per stage
// depends on mea_pkg
`timescale 1ns / 1ps

module mea_div_stage
   import mea_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         valid_in,
   input  mea_pipe_type pipe_in,
   output logic         valid_out,
   output mea_pipe_type pipe_out
);

   logic         valid_ff;
   mea_pipe_type pipe_ff, step_in;
   logic [32:0]  trial, diff;

   // shift in the next dividend bit and try to subtract the divisor
   assign trial = {pipe_in.rem, pipe_in.quo[31]};
   assign diff  = trial - {1'b0, pipe_in.divisor};

   always_comb begin
      step_in = pipe_in;
      if (!diff[32]) begin
         step_in.rem = diff[31:0];
         step_in.quo = {pipe_in.quo[30:0], 1'b1};
      end else begin
         step_in.rem = trial[31:0];
         step_in.quo = {pipe_in.quo[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= step_in;
      end
   end

   assign valid_out = valid_ff;
   assign pipe_out  = pipe_ff;

endmodule

### tb/mips_execute_alu_top_tb.sv
// mips_execute_alu_top_tb: self-checking bench for the mips execute alu
// depends on mea_pkg and mips_execute_alu_top
`timescale 1ns / 1ps

module mips_execute_alu_top_tb;
   import mea_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   mea_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   mea_rsp_type rsp_payload;

   mea_rsp_type expected_results[$];
   int          error_count = 0;
   int          request_count = 0;
   int          result_count = 0;
   int          divide_count = 0;
   int          multiply_count = 0;
   longint      tick_total = 0;

   localparam longint CYCLE_LIMIT = 400000;

   // directed table: instruction, operands, and a typed result where obvious
   typedef struct {
      mea_req_type req;
      logic        has_result;
      mea_rsp_type result;
   } directed_row_type;

   mips_execute_alu_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #4 clock = ~clock;

   // timeout guard
   always @(posedge clock) begin
      tick_total <= tick_total + 1;
      if (tick_total > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] r_type(logic [5:0] fn, logic [4:0] shamt);
      return {OP_SPECIAL, 5'd3, 5'd4, 5'd5, shamt, fn};
   endfunction

   function automatic logic [31:0] i_type(logic [5:0] op, logic [15:0] imm);
      return {op, 5'd1, 5'd2, imm};
   endfunction

   function automatic mea_rsp_type make_rsp(logic [31:0] alu, logic [31:0] hi,
                                            logic [31:0] lo, logic [2:0] code);
      mea_rsp_type r;
      r.alu_value = alu;
      r.hi_value  = hi;
      r.lo_value  = lo;
      r.outcome   = code;
      return r;
   endfunction

   // execute-stage predictor
   function automatic mea_rsp_type execute_instr(mea_req_type rq);
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  sh;
      logic [31:0] imz;
      logic [31:0] ims;
      logic [31:0] a;
      logic [31:0] b;
      logic [63:0] prod;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      logic [31:0] r;
      op  = rq.instruction[31:26];
      fn  = rq.instruction[5:0];
      sh  = rq.instruction[10:6];
      imz = {16'h0, rq.instruction[15:0]};
      ims = {{16{rq.instruction[15]}}, rq.instruction[15:0]};
      a   = rq.operand_a;
      b   = rq.operand_b;
      if (op == OP_SPECIAL) begin
         case (fn)
            FN_SLL: return make_rsp(b << sh, '0, '0, OUT_ALU);
            FN_SRL: return make_rsp(b >> sh, '0, '0, OUT_ALU);
            FN_SRA: return make_rsp($unsigned($signed(b) >>> sh), '0, '0, OUT_ALU);
            FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO:
               return make_rsp('0, '0, '0, OUT_NOWORK);
            FN_MULT: begin
               prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
               return make_rsp('0, prod[63:32], prod[31:0], OUT_HILO);
            end
            FN_MULTU: begin
               prod = {32'h0, a} * {32'h0, b};
               return make_rsp('0, prod[63:32], prod[31:0], OUT_HILO);
            end
            FN_DIV: begin
               if (b == 0) return make_rsp('0, '0, '0, OUT_DIVZERO);
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               q = ma / mb;
               r = ma % mb;
               if (a[31] ^ b[31]) q = -q;
               if (a[31]) r = -r;
               return make_rsp('0, r, q, OUT_HILO);
            end
            FN_DIVU: begin
               if (b == 0) return make_rsp('0, '0, '0, OUT_DIVZERO);
               return make_rsp('0, a % b, a / b, OUT_HILO);
            end
            FN_ADD, FN_ADDU: return make_rsp(a + b, '0, '0, OUT_ALU);
            FN_SUB, FN_SUBU: return make_rsp(a - b, '0, '0, OUT_ALU);
            FN_AND:  return make_rsp(a & b, '0, '0, OUT_ALU);
            FN_OR:   return make_rsp(a | b, '0, '0, OUT_ALU);
            FN_XOR:  return make_rsp(a ^ b, '0, '0, OUT_ALU);
            FN_NOR:  return make_rsp(~(a | b), '0, '0, OUT_ALU);
            FN_SLT:  return make_rsp({31'h0, $signed(a) < $signed(b)}, '0, '0, OUT_ALU);
            default: return make_rsp('0, '0, '0, OUT_UNKNOWN);
         endcase
      end
      case (op)
         OP_ADDI, OP_ADDIU: return make_rsp(a + ims, '0, '0, OUT_ALU);
         OP_SLTI: return make_rsp({31'h0, $signed(a) < $signed(ims)}, '0, '0, OUT_ALU);
         OP_ANDI: return make_rsp(a & imz, '0, '0, OUT_ALU);
         OP_ORI:  return make_rsp(a | imz, '0, '0, OUT_ALU);
         OP_XORI: return make_rsp(a ^ imz, '0, '0, OUT_ALU);
         OP_LUI, OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW:
            return make_rsp('0, '0, '0, OUT_NOWORK);
         default: return make_rsp('0, '0, '0, OUT_UNKNOWN);
      endcase
   endfunction

   // random operand biased toward edge values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_instruction();
      logic [31:0] word;
      logic [5:0]  codes[20];
      logic [5:0]  ops[13];
      codes = '{FN_SLL, FN_SRL, FN_SRA, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
                FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
                FN_OR, FN_XOR, FN_NOR, FN_SLT};
      ops = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB,
              OP_LH, OP_LW, OP_SB, OP_SH, OP_SW};
      word = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: word = {OP_SPECIAL, word[25:6], codes[$urandom_range(0, 19)]};
         5, 6, 7, 8: word = {ops[$urandom_range(0, 12)], word[25:0]};
         default: ;
      endcase
      return word;
   endfunction

   // send one request and record its predicted result
   task automatic send_request(mea_req_type rq);
      req_valid   <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(execute_instr(rq));
      request_count++;
      if (rq.instruction[31:26] == OP_SPECIAL &&
          (rq.instruction[5:0] == FN_DIV || rq.instruction[5:0] == FN_DIVU))
         divide_count++;
      if (rq.instruction[31:26] == OP_SPECIAL &&
          (rq.instruction[5:0] == FN_MULT || rq.instruction[5:0] == FN_MULTU))
         multiply_count++;
   endtask

   task automatic idle_cycles(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      mea_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_results.size() == 0) begin
            $error("unexpected result %p", rsp_payload);
            error_count++;
         end else begin
            exp_rsp = expected_results.pop_front();
            if (rsp_payload.alu_value !== exp_rsp.alu_value) begin
               $error("alu_value: expected %h actual %h", exp_rsp.alu_value,
                      rsp_payload.alu_value);
               error_count++;
            end
            if (rsp_payload.hi_value !== exp_rsp.hi_value) begin
               $error("hi_value: expected %h actual %h", exp_rsp.hi_value,
                      rsp_payload.hi_value);
               error_count++;
            end
            if (rsp_payload.lo_value !== exp_rsp.lo_value) begin
               $error("lo_value: expected %h actual %h", exp_rsp.lo_value,
                      rsp_payload.lo_value);
               error_count++;
            end
            if (rsp_payload.outcome !== exp_rsp.outcome) begin
               $error("outcome: expected %0d actual %0d", exp_rsp.outcome,
                      rsp_payload.outcome);
               error_count++;
            end
         end
      end
   end

   // receiver stall pattern: quiet stretches, light stretches, heavy stretches
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (tick_total[9:8] == 2'd0)
         rsp_stall <= 1'b0;
      else if (tick_total[9:8] == 2'd1)
         rsp_stall <= ($urandom_range(0, 3) == 0);
      else
         rsp_stall <= ($urandom_range(0, 9) < 6);
   end

   // stimulus
   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      mea_req_type      rq;
      mea_rsp_type      got;
      int               burst;
      int               drain;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      row.has_result = 1'b1;
      row.req = '{r_type(FN_ADD, 0), 32'h7FFF_FFFF, 32'h1};
      row.result = make_rsp(32'h8000_0000, 0, 0, OUT_ALU); rows.push_back(row);
      row.req = '{r_type(FN_SUBU, 0), 32'h0, 32'h1};
      row.result = make_rsp(32'hFFFF_FFFF, 0, 0, OUT_ALU); rows.push_back(row);
      row.req = '{r_type(FN_SRA, 5'd31), 32'h0, 32'h8000_0000};
      row.result = make_rsp(32'hFFFF_FFFF, 0, 0, OUT_ALU); rows.push_back(row);
      row.req = '{r_type(FN_SRL, 5'd31), 32'h0, 32'h8000_0000};
      row.result = make_rsp(32'h1, 0, 0, OUT_ALU); rows.push_back(row);
      row.req = '{r_type(FN_SLL, 5'd31), 32'hFFFF_FFFF, 32'h1};
      row.result = make_rsp(32'h8000_0000, 0, 0, OUT_ALU); rows.push_back(row);
      row.req = '{r_type(FN_SLT, 0), 32'h8000_0000, 32'h1};
      row.result = make_rsp(32'h1, 0, 0, OUT_ALU); rows.push_back(row);
      row.req = '{r_type(FN_DIV, 0), 32'h8000_0000, 32'hFFFF_FFFF};
      row.result = make_rsp(0, 32'h0, 32'h8000_0000, OUT_HILO); rows.push_back(row);
      row.req = '{r_type(FN_DIV, 0), 32'h5, 32'h0};
      row.result = make_rsp(0, 0, 0, OUT_DIVZERO); rows.push_back(row);
      row.req = '{r_type(FN_DIVU, 0), 32'hFFFF_FFFF, 32'h0};
      row.result = make_rsp(0, 0, 0, OUT_DIVZERO); rows.push_back(row);
      row.req = '{r_type(FN_MULTU, 0), 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      row.result = make_rsp(0, 32'hFFFF_FFFE, 32'h1, OUT_HILO); rows.push_back(row);
      row.req = '{r_type(FN_MULT, 0), 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      row.result = make_rsp(0, 32'h0, 32'h1, OUT_HILO); rows.push_back(row);
      row.req = '{r_type(FN_MFHI, 0), 32'h1234, 32'h5678};
      row.result = make_rsp(0, 0, 0, OUT_NOWORK); rows.push_back(row);
      row.req = '{i_type(OP_LW, 16'hFFFC), 32'h1234, 32'h5678};
      row.result = make_rsp(0, 0, 0, OUT_NOWORK); rows.push_back(row);
      row.req = '{r_type(6'h0C, 0), 32'h1, 32'h2};
      row.result = make_rsp(0, 0, 0, OUT_UNKNOWN); rows.push_back(row);
      row.req = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      row.result = make_rsp(0, 0, 0, OUT_UNKNOWN); rows.push_back(row);
      row.req = '{i_type(OP_ADDI, 16'hFFFF), 32'h0, 32'h0};
      row.result = make_rsp(32'hFFFF_FFFF, 0, 0, OUT_ALU); rows.push_back(row);
      row.req = '{i_type(OP_ORI, 16'hFFFF), 32'h0, 32'h0};
      row.result = make_rsp(32'h0000_FFFF, 0, 0, OUT_ALU); rows.push_back(row);
      // the rest is checked by the predictor only
      row.has_result = 1'b0;
      row.req = '{r_type(FN_DIV, 0), 32'hFFFF_FFF9, 32'h2}; rows.push_back(row);
      row.req = '{r_type(FN_MULT, 0), 32'h8000_0000, 32'h7FFF_FFFF}; rows.push_back(row);
      row.req = '{r_type(FN_NOR, 0), 32'hF0F0_0000, 32'h0000_0F0F}; rows.push_back(row);
      row.req = '{r_type(FN_XOR, 0), 32'hAAAA_5555, 32'hFFFF_0000}; rows.push_back(row);
      row.req = '{r_type(FN_AND, 0), 32'hAAAA_5555, 32'h0FF0_0FF0}; rows.push_back(row);
      row.req = '{i_type(OP_SLTI, 16'h8000), 32'hFFFF_0000, 32'h0}; rows.push_back(row);
      row.req = '{i_type(OP_XORI, 16'h8001), 32'h8000_0000, 32'h0}; rows.push_back(row);
      row.req = '{i_type(OP_ANDI, 16'hFFFF), 32'h8765_4321, 32'h0}; rows.push_back(row);

      foreach (rows[i]) begin
         if (rows[i].has_result) begin
            got = execute_instr(rows[i].req);
            if (got !== rows[i].result) begin
               $error("table row %0d: expected %p predicted %p", i, rows[i].result, got);
               error_count++;
            end
         end
         send_request(rows[i].req);
      end

      // random bursts with random gaps
      while (request_count < 630) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            rq.instruction = pick_instruction();
            rq.operand_a   = pick_operand();
            rq.operand_b   = pick_operand();
            send_request(rq);
         end
         if ($urandom_range(0, 1)) idle_cycles($urandom_range(1, 12));
         // full drain after each burst that ends between 301 and 340 requests
         if (request_count > 300 && request_count < 341) begin
            req_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // wait for the pipeline to empty
      drain = 0;
      while (expected_results.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (40) @(posedge clock);

      $display("sent %0d requests, checked %0d results", request_count, result_count);
      $display("including %0d divides and %0d multiplies", divide_count, multiply_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         if (expected_results.size() != 0)
            $error("%0d results never arrived", expected_results.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

### mips_execute_alu_top.f
design/mea_pkg.sv
design/mea_decode.sv
design/mea_div_stage.sv
design/mips_execute_alu_top.sv
tb/mips_execute_alu_top_tb.sv
